/* rtl/assert_macros.svh */
// Assertion macros for the accumulator ALU.
// Each assertion is sampled on clk and is disabled while rst_n is low.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPUALU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");
`define CPUALU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPUALU_ASSERT_IMPL(lbl, ante, cons)
`define CPUALU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/cpualu_pkg.sv */
// Package for the accumulator ALU: operation codes, flag positions and
// decimal adjust constants. No dependencies.
package cpualu_pkg;

    localparam int unsigned KIND_W  = 5;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned FLAGS_W = 4;

    localparam logic [KIND_W-1:0] OP_ADD  = 5'd0;
    localparam logic [KIND_W-1:0] OP_ADC  = 5'd1;
    localparam logic [KIND_W-1:0] OP_SUB  = 5'd2;
    localparam logic [KIND_W-1:0] OP_SBC  = 5'd3;
    localparam logic [KIND_W-1:0] OP_AND  = 5'd4;
    localparam logic [KIND_W-1:0] OP_XOR  = 5'd5;
    localparam logic [KIND_W-1:0] OP_OR   = 5'd6;
    localparam logic [KIND_W-1:0] OP_CP   = 5'd7;
    localparam logic [KIND_W-1:0] OP_INC  = 5'd8;
    localparam logic [KIND_W-1:0] OP_DEC  = 5'd9;
    localparam logic [KIND_W-1:0] OP_RLCA = 5'd10;
    localparam logic [KIND_W-1:0] OP_RRCA = 5'd11;
    localparam logic [KIND_W-1:0] OP_RLA  = 5'd12;
    localparam logic [KIND_W-1:0] OP_RRA  = 5'd13;
    localparam logic [KIND_W-1:0] OP_DAA  = 5'd14;
    localparam logic [KIND_W-1:0] OP_CPL  = 5'd15;
    localparam logic [KIND_W-1:0] OP_SCF  = 5'd16;
    localparam logic [KIND_W-1:0] OP_CCF  = 5'd17;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [3:0]        NIBBLE_MAX  = 4'hF;
    localparam logic [3:0]        DAA_LOW_MAX = 4'h9;
    localparam logic [DATA_W-1:0] DAA_MAX     = 8'h99;
    localparam logic [3:0]        DAA_STEP    = 4'h6;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  acc;
        logic [DATA_W-1:0]  operand;
        logic [FLAGS_W-1:0] flags;
    } alu_op_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [FLAGS_W-1:0] flags;
    } alu_res_t;

endpackage

/* rtl/cpu_alu_with_flags.sv */
// Top level of the accumulator ALU: input register, datapath, result register.
// Depends on cpualu_pkg, cpualu_core and assert_macros.svh.
//
// Usage:
//   Drive kind, accumulator_in, operand and flags_in and raise start for one
//   cycle per operation. busy is always low, so a beat is taken at every
//   rising edge where start is high: one operation per cycle, sustained.
//   The operation is captured in the input register, evaluated by the
//   datapath in one pass and captured in the result register. done is high
//   for exactly one cycle with result and flags_out, once the beat has passed
//   the input register and then the result register.
//   Back-to-back beats give back-to-back results in the same order.
//   The receiver cannot stall; each result is valid for its one cycle only.
//   Reset (rst_n low, asynchronous) drops any operation in flight; done
//   stays low until a new beat has passed both registers.
//   Unused kind codes return accumulator_in and flags_in unchanged.
module cpu_alu_with_flags
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] kind,
    input  logic [7:0] accumulator_in,
    input  logic [7:0] operand,
    input  logic [3:0] flags_in,
    output logic       done,
    output logic [7:0] result,
    output logic [3:0] flags_out
);

    logic                 take;
    logic                 valid_reg;
    cpualu_pkg::alu_op_t  op_reg;
    cpualu_pkg::alu_op_t  op_next;
    cpualu_pkg::alu_res_t res_next;
    logic                 done_reg;
    cpualu_pkg::alu_res_t res_reg;
    logic                 cp_in_reg;

    assign busy = 1'b0;
    assign take = start && !busy;

    assign op_next.kind    = kind;
    assign op_next.acc     = accumulator_in;
    assign op_next.operand = operand;
    assign op_next.flags   = flags_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op_next;
        end
        if (valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    cpualu_core u_core
    (
        .op  (op_reg),
        .res (res_next)
    );

    assign done      = done_reg;
    assign result    = res_reg.result;
    assign flags_out = res_reg.flags;

    assign cp_in_reg = valid_reg && (op_reg.kind == cpualu_pkg::OP_CP);

`include "assert_macros.svh"

    `CPUALU_ASSERT_IMPL(a_beat_gives_result, take, ##2 done)
    `CPUALU_ASSERT_IMPL(a_no_spurious_result, !take, ##2 !done)
    `CPUALU_ASSERT_NEXT(a_cp_keeps_acc, cp_in_reg, result == $past(op_reg.acc))

endmodule

/* rtl/cpualu_core.sv */
// Combinational datapath of the accumulator ALU: one operation to one
// result byte and flag nibble. Depends on cpualu_pkg.
module cpualu_core
(
    input  cpualu_pkg::alu_op_t  op,
    output cpualu_pkg::alu_res_t res
);

    logic [7:0] a;
    logic [7:0] b;
    logic       zf;
    logic       nf;
    logic       hf;
    logic       cf;
    logic       t;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic       daa_c;
    logic       daa_l;
    logic [7:0] daa_adj;
    logic [7:0] daa_r;
    logic [7:0] r;
    logic       z_o;
    logic       n_o;
    logic       h_o;
    logic       c_o;
    logic       z_from_r;

    assign a  = op.acc;
    assign b  = op.operand;
    assign zf = op.flags[cpualu_pkg::FLAG_Z];
    assign nf = op.flags[cpualu_pkg::FLAG_N];
    assign hf = op.flags[cpualu_pkg::FLAG_H];
    assign cf = op.flags[cpualu_pkg::FLAG_C];
    assign t  = (op.kind == cpualu_pkg::OP_ADC || op.kind == cpualu_pkg::OP_SBC) ? cf : 1'b0;

    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, t};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, t};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
    assign inc_r   = b + 8'd1;
    assign dec_r   = b - 8'd1;

    assign daa_c   = nf ? cf : (cf || a > cpualu_pkg::DAA_MAX);
    assign daa_l   = nf ? hf : (hf || a[3:0] > cpualu_pkg::DAA_LOW_MAX);
    assign daa_adj = {daa_c ? cpualu_pkg::DAA_STEP : 4'h0, daa_l ? cpualu_pkg::DAA_STEP : 4'h0};
    assign daa_r   = nf ? a - daa_adj : a + daa_adj;

    always_comb
    begin
        r        = a;
        z_from_r = 1'b1;
        z_o      = zf;
        n_o      = nf;
        h_o      = hf;
        c_o      = cf;
        case (op.kind)
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC:
            begin
                r   = sum9[7:0];
                n_o = 1'b0;
                h_o = sum_lo[4];
                c_o = sum9[8];
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
            begin
                r   = diff9[7:0];
                n_o = 1'b1;
                h_o = diff_lo[4];
                c_o = diff9[8];
            end
            cpualu_pkg::OP_AND:
            begin
                r   = a & b;
                n_o = 1'b0;
                h_o = 1'b1;
                c_o = 1'b0;
            end
            cpualu_pkg::OP_XOR:
            begin
                r   = a ^ b;
                n_o = 1'b0;
                h_o = 1'b0;
                c_o = 1'b0;
            end
            cpualu_pkg::OP_OR:
            begin
                r   = a | b;
                n_o = 1'b0;
                h_o = 1'b0;
                c_o = 1'b0;
            end
            cpualu_pkg::OP_INC:
            begin
                r   = inc_r;
                n_o = 1'b0;
                h_o = (b[3:0] == cpualu_pkg::NIBBLE_MAX);
            end
            cpualu_pkg::OP_DEC:
            begin
                r   = dec_r;
                n_o = 1'b1;
                h_o = (b[3:0] == 4'h0);
            end
            cpualu_pkg::OP_RLCA:
            begin
                r        = {a[6:0], a[7]};
                z_from_r = 1'b0;
                z_o      = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = a[7];
            end
            cpualu_pkg::OP_RRCA:
            begin
                r        = {a[0], a[7:1]};
                z_from_r = 1'b0;
                z_o      = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = a[0];
            end
            cpualu_pkg::OP_RLA:
            begin
                r        = {a[6:0], cf};
                z_from_r = 1'b0;
                z_o      = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = a[7];
            end
            cpualu_pkg::OP_RRA:
            begin
                r        = {cf, a[7:1]};
                z_from_r = 1'b0;
                z_o      = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = a[0];
            end
            cpualu_pkg::OP_DAA:
            begin
                r   = daa_r;
                h_o = 1'b0;
                c_o = daa_c;
            end
            cpualu_pkg::OP_CPL:
            begin
                r        = ~a;
                z_from_r = 1'b0;
                n_o      = 1'b1;
                h_o      = 1'b1;
            end
            cpualu_pkg::OP_SCF:
            begin
                z_from_r = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = 1'b1;
            end
            cpualu_pkg::OP_CCF:
            begin
                z_from_r = 1'b0;
                n_o      = 1'b0;
                h_o      = 1'b0;
                c_o      = ~cf;
            end
            default:
            begin
                z_from_r = 1'b0;
            end
        endcase
        if (z_from_r)
        begin
            z_o = (r == 8'h00);
        end
    end

    assign res.result = (op.kind == cpualu_pkg::OP_CP) ? a : r;
    assign res.flags  = {z_o, n_o, h_o, c_o};

endmodule
